### src/bds_pkg.sv
`default_nettype none
package bds_pkg;

  localparam int MAX_COLUMNS   = 1024;
  localparam int MAX_ROWS      = 512;
  localparam int FRACTION_BITS = 8;
  localparam int DEPTH_BITS    = 16;

  localparam int COL_BITS  = $clog2(MAX_COLUMNS);
  localparam int ROW_BITS  = $clog2(MAX_ROWS);
  localparam int ADDR_BITS = COL_BITS + ROW_BITS;
  localparam int MEM_DEPTH = MAX_COLUMNS * MAX_ROWS;

  localparam int X_BITS   = 18;
  localparam int Y_BITS   = 17;
  localparam int DV_BITS  = 17;
  localparam int OUT_BITS = 17;
  localparam int W_BITS   = 11;
  localparam int H_BITS   = 10;
  localparam int DIFF_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam int WT_BITS  = 2 * FRACTION_BITS + 1;
  localparam int ACC_BITS = WT_BITS + DEPTH_BITS + 1;
  localparam int QB       = DEPTH_BITS;

  localparam logic [W_BITS-1:0]    MAP_WIDTH_RST  = W_BITS'(1024);
  localparam logic [H_BITS-1:0]    MAP_HEIGHT_RST = H_BITS'(512);
  localparam logic [DIFF_BITS-1:0] MAX_DIFF_RST   = DIFF_BITS'(800);
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX     = {DEPTH_BITS{1'b1}};

  typedef logic signed [DEPTH_BITS:0] depth_t;
  localparam depth_t DEPTH_INVALID = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MAP_WIDTH  = 2'd0,
    CFG_MAP_HEIGHT = 2'd1,
    CFG_MAX_DIFF   = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_SAMPLE,
    CMD_OUTSIDE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [COL_BITS-1:0]      xl;
    logic [ROW_BITS-1:0]      yl;
    logic [FRACTION_BITS-1:0] fx;
    logic [FRACTION_BITS-1:0] fy;
    depth_t                   depth;
  } cmd_t;

  typedef struct packed {
    logic [W_BITS-1:0] w_eff;
    logic [H_BITS-1:0] h_eff;
  } geom_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

### src/bds_front.sv
`default_nettype none
module bds_front import bds_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire geom_t                 geom,
  input  wire logic                  hold,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_operation,
  input  wire logic [X_BITS-1:0]     in_x_pos,
  input  wire logic [Y_BITS-1:0]     in_y_pos,
  input  wire logic signed [DV_BITS-1:0] in_depth_value,
  input  wire q_status_t             q_stat,
  output logic                       push,
  output cmd_t                       push_cmd
);

  logic  v_r;
  cmd_t  cmd_r;
  cmd_t  cmd_nxt;
  logic  keep_nxt;
  logic  accept;
  logic [X_BITS-FRACTION_BITS-1:0] xi;
  logic [Y_BITS-FRACTION_BITS-1:0] yi;
  logic [W_BITS+FRACTION_BITS-1:0] lim_x;
  logic [H_BITS+FRACTION_BITS-1:0] lim_y;
  logic outside;

  assign in_stall = hold || (v_r && q_stat.full);
  assign accept   = in_valid && !in_stall;
  assign push     = v_r && !q_stat.full;
  assign push_cmd = cmd_r;

  assign xi    = in_x_pos[X_BITS-1:FRACTION_BITS];
  assign yi    = in_y_pos[Y_BITS-1:FRACTION_BITS];
  assign lim_x = {geom.w_eff - W_BITS'(1), {FRACTION_BITS{1'b0}}};
  assign lim_y = {geom.h_eff - H_BITS'(1), {FRACTION_BITS{1'b0}}};
  assign outside = (geom.w_eff == '0) || (geom.h_eff == '0) ||
                   ((W_BITS+FRACTION_BITS)'(in_x_pos) > lim_x) ||
                   ((H_BITS+FRACTION_BITS)'(in_y_pos) > lim_y);

  always_comb begin
    cmd_nxt.xl = COL_BITS'(xi);
    cmd_nxt.yl = ROW_BITS'(yi);
    cmd_nxt.fx = in_x_pos[FRACTION_BITS-1:0];
    cmd_nxt.fy = in_y_pos[FRACTION_BITS-1:0];
    if (in_depth_value[DV_BITS-1]) begin
      cmd_nxt.depth = DEPTH_INVALID;
    end else if (in_depth_value[DV_BITS-2:0] > (DV_BITS-1)'(DEPTH_MAX)) begin
      cmd_nxt.depth = {1'b0, DEPTH_MAX};
    end else begin
      cmd_nxt.depth = depth_t'(in_depth_value[DV_BITS-2:0]);
    end
    keep_nxt = 1'b1;
    if (!in_operation) begin
      cmd_nxt.kind = CMD_WRITE;
      // writes outside the map in use are dropped here
      keep_nxt = ((W_BITS+1)'(xi) < (W_BITS+1)'(geom.w_eff)) &&
                 ((H_BITS+1)'(yi) < (H_BITS+1)'(geom.h_eff));
    end else if (outside) begin
      cmd_nxt.kind = CMD_OUTSIDE;
    end else begin
      cmd_nxt.kind = CMD_SAMPLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (accept) begin
      v_r <= keep_nxt;
    end else if (push) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule
`default_nettype wire

### src/bds_queue.sv
`default_nettype none
module bds_queue import bds_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output q_status_t q_stat
);

  localparam int QDEPTH = 4;
  localparam int PB = $clog2(QDEPTH);

  cmd_t          mem_r [QDEPTH];
  logic [PB-1:0] wp_r;
  logic [PB-1:0] rp_r;
  logic [PB:0]   cnt_r;
  logic          do_push;
  logic          do_pop;

  assign q_stat.full  = (cnt_r == (PB+1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;
  assign head    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + PB'(1);
      if (do_pop)  rp_r <= rp_r + PB'(1);
      cnt_r <= cnt_r + (PB+1)'(do_push) - (PB+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

### src/bds_back.sv
`default_nettype none
module bds_back import bds_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [DIFF_BITS-1:0]  max_diff,
  input  wire cmd_t                  head,
  input  wire q_status_t             q_stat,
  output logic                       pop,
  output logic                       clearing,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [OUT_BITS-1:0] out_sampled_depth
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_EVAL, S_MAC, S_DIV, S_DONE
  } state_t;

  localparam int DCB = $clog2(QB + 1);

  state_t                 state_r;
  logic [ADDR_BITS-1:0]   clr_addr_r;
  logic [2:0]             cnt_r;
  logic [DCB-1:0]         dcnt_r;
  cmd_t                   cmd_r;
  depth_t                 d_r  [4];
  logic [WT_BITS-1:0]     wt_r [4];
  logic [WT_BITS-1:0]     ws_r;
  logic [ACC_BITS-1:0]    acc_r;
  logic [WT_BITS-1:0]     rem_r;
  logic [QB-1:0]          sh_r;
  depth_t                 res_r;
  logic                   out_valid_r;
  depth_t                 out_depth_r;

  depth_t                 mem [MEM_DEPTH];
  depth_t                 rd_data_r;
  logic                   mem_we;
  logic [ADDR_BITS-1:0]   mem_waddr;
  depth_t                 mem_wdata;
  logic [ADDR_BITS-1:0]   mem_raddr;

  logic                   out_free;
  logic                   out_set;
  logic [1:0]             corner;
  logic [COL_BITS-1:0]    cx;
  logic [ROW_BITS-1:0]    cy;
  logic [FRACTION_BITS:0] wx;
  logic [FRACTION_BITS:0] wy;
  logic [WT_BITS-1:0]     wt_now;
  logic [WT_BITS-1:0]     wm [4];
  depth_t                 mn;
  depth_t                 mx;
  logic [DEPTH_BITS+1:0]  spread;
  logic [1:0]             best;
  logic [WT_BITS-1:0]     ws_sum;
  logic [ACC_BITS-1:0]    acc_sum;
  logic [WT_BITS:0]       trial;
  logic                   ge;

  assign clearing          = (state_r == S_CLEAR);
  assign out_valid         = out_valid_r;
  assign out_sampled_depth = OUT_BITS'(out_depth_r);
  assign out_free          = !out_valid_r || !out_stall;
  assign pop               = (state_r == S_IDLE) && !q_stat.empty && out_free;
  assign out_set           = (pop && head.kind == CMD_OUTSIDE) ||
                             (state_r == S_DONE && out_free);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // corner order: (xl,yl) (xh,yl) (xh,yh) (xl,yh)
  always_comb begin
    corner = cnt_r[1:0];
    cx = cmd_r.xl;
    cy = cmd_r.yl;
    wx = (FRACTION_BITS+1)'(1 << FRACTION_BITS) - (FRACTION_BITS+1)'(cmd_r.fx);
    wy = (FRACTION_BITS+1)'(1 << FRACTION_BITS) - (FRACTION_BITS+1)'(cmd_r.fy);
    if (corner == 2'd1 || corner == 2'd2) begin
      cx = cmd_r.xl + COL_BITS'(cmd_r.fx != '0);
      wx = (FRACTION_BITS+1)'(cmd_r.fx);
    end
    if (corner == 2'd2 || corner == 2'd3) begin
      cy = cmd_r.yl + ROW_BITS'(cmd_r.fy != '0);
      wy = (FRACTION_BITS+1)'(cmd_r.fy);
    end
    wt_now = WT_BITS'(wx * wy);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {head.yl, head.xl};
    mem_wdata = head.depth;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = DEPTH_INVALID;
    end else if (pop && head.kind == CMD_WRITE) begin
      mem_we = 1'b1;
    end
    mem_raddr = {cy, cx};
  end

  always_comb begin
    mn = d_r[0];
    mx = d_r[0];
    for (int i = 1; i < 4; i++) begin
      if (d_r[i] < mn) mn = d_r[i];
      if (d_r[i] > mx) mx = d_r[i];
    end
    for (int i = 0; i < 4; i++) begin
      wm[i] = d_r[i][DEPTH_BITS] ? '0 : wt_r[i];
    end
    spread = (DEPTH_BITS+2)'(mx) - (DEPTH_BITS+2)'(mn);
    best = 2'd0;
    for (int i = 1; i < 4; i++) begin
      if (wm[i] > wm[best]) best = 2'(i);
    end
    ws_sum = wm[0] + wm[1] + wm[2] + wm[3];
    acc_sum = acc_r + ACC_BITS'(wt_r[corner] * d_r[corner][DEPTH_BITS-1:0]);
    trial = {rem_r, sh_r[QB-1]};
    ge = (trial >= {1'b0, ws_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      cnt_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_set || (out_valid_r && out_stall);
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + ADDR_BITS'(1);
          if (clr_addr_r == ADDR_BITS'(MEM_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (pop) begin
            cmd_r <= head;
            cnt_r <= '0;
            unique case (head.kind)
              CMD_SAMPLE: state_r <= S_READ;
              CMD_OUTSIDE: begin
                out_depth_r <= DEPTH_INVALID;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          if (cnt_r != 3'd4) wt_r[corner] <= wt_now;
          if (cnt_r != 3'd0) d_r[2'(cnt_r - 3'd1)] <= rd_data_r;
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd4) state_r <= S_EVAL;
        end
        S_EVAL: begin
          if ((DEPTH_BITS+2)'(max_diff) < spread) begin
            res_r   <= d_r[best];
            state_r <= S_DONE;
          end else begin
            for (int i = 0; i < 4; i++) wt_r[i] <= wm[i];
            ws_r    <= ws_sum;
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          acc_r <= acc_sum;
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd3) begin
            // quotient fits QB bits, so the high part is already below ws
            rem_r  <= WT_BITS'(acc_sum >> QB);
            sh_r   <= acc_sum[QB-1:0];
            dcnt_r <= '0;
            if (ws_r == '0) begin
              res_r   <= DEPTH_INVALID;
              state_r <= S_DONE;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_r  <= ge ? WT_BITS'(trial - {1'b0, ws_r}) : WT_BITS'(trial);
          sh_r   <= {sh_r[QB-2:0], ge};
          dcnt_r <= dcnt_r + DCB'(1);
          if (dcnt_r == DCB'(QB - 1)) begin
            res_r   <= depth_t'({sh_r[QB-2:0], ge});
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_depth_r <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### src/bilinear_depth_sampler_unit.sv
// Writes reach the depth store through the front register and the queue.
// A sample passes 4 corner reads, 1 evaluate, 4 multiply-accumulate steps,
// 16 divide steps and 1 output step; the back end takes one sample at a time.
// Wide spread skips multiply and divide; off-map goes straight to the output.
// After reset the depth store is swept to invalid, all 524288 entries, one entry a
// cycle; no input is taken meanwhile. Config writes are always taken.
`default_nettype none
module bilinear_depth_sampler_unit import bds_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_operation,
  input  wire logic [X_BITS-1:0]         in_x_pos,
  input  wire logic [Y_BITS-1:0]         in_y_pos,
  input  wire logic signed [DV_BITS-1:0] in_depth_value,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [OUT_BITS-1:0]     out_sampled_depth,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [W_BITS-1:0]    map_width_r;
  logic [H_BITS-1:0]    map_height_r;
  logic [DIFF_BITS-1:0] max_diff_r;
  geom_t                geom;
  q_status_t            q_stat;
  logic                 push;
  cmd_t                 push_cmd;
  logic                 pop;
  cmd_t                 head;
  logic                 clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= MAP_WIDTH_RST;
      map_height_r <= MAP_HEIGHT_RST;
      max_diff_r   <= MAX_DIFF_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAP_WIDTH:  map_width_r  <= W_BITS'(cfg_data);
        CFG_MAP_HEIGHT: map_height_r <= H_BITS'(cfg_data);
        CFG_MAX_DIFF:   max_diff_r   <= cfg_data;
        CFG_UNUSED:     ;
      endcase
    end
  end

  assign geom.w_eff = (map_width_r > W_BITS'(MAX_COLUMNS)) ? W_BITS'(MAX_COLUMNS)
                                                           : map_width_r;
  assign geom.h_eff = (map_height_r > H_BITS'(MAX_ROWS)) ? H_BITS'(MAX_ROWS)
                                                         : map_height_r;

  bds_front u_front (
    .clk, .rst_n, .geom, .hold(clearing),
    .in_valid, .in_stall, .in_operation, .in_x_pos, .in_y_pos, .in_depth_value,
    .q_stat, .push, .push_cmd
  );

  bds_queue u_queue (
    .clk, .rst_n, .push, .push_cmd, .pop, .head, .q_stat
  );

  bds_back u_back (
    .clk, .rst_n, .max_diff(max_diff_r), .head, .q_stat, .pop, .clearing,
    .out_valid, .out_stall, .out_sampled_depth
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !(push && !pop)) else $error("request lost: queue full");
  a_no_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid) else $error("result while store clearing");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("pop from empty queue");
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sampled_depth >= -17'sd1) else $error("depth out of range");
`endif

endmodule
`default_nettype wire
